// ===== design/spam_pkg.sv =====
// types and constants shared by the static pixel age masker
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package spam_pkg;

  localparam int POS_W    = 10;
  localparam int POS_SPAN = 1 << POS_W;
  localparam int CHAN_W   = 8;
  localparam int COLOUR_W = 3 * CHAN_W;
  localparam int AGE_W    = 8;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  localparam logic [AGE_W-1:0]  THRESHOLD_RESET = 8'd2;
  localparam logic [AGE_W-1:0]  MAX_AGE_RESET   = 8'd150;

  // register index codes, taken from paddr[2]
  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_MAX_AGE   = 1'b1;

  // request commands
  localparam logic CMD_COMPARE = 1'b0;
  localparam logic CMD_CLEAR   = 1'b1;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } colour_t;

  typedef struct packed {
    colour_t          colour;
    logic [AGE_W-1:0] age;
    logic             mask;
  } entry_t;

  typedef struct packed {
    logic [CHAN_W-1:0] threshold;
    logic [AGE_W-1:0]  max_age;
  } cfg_t;

  typedef struct packed {
    logic             masked;
    logic             newly_masked;
    logic [AGE_W-1:0] age_now;
  } result_t;

  function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                 input logic [CHAN_W-1:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

endpackage

`default_nettype wire

// ===== design/spam_ifs.sv =====
// request and result channel interfaces for the static pixel age masker
// depends on spam_pkg
`timescale 1ns / 1ps
`default_nettype none

interface spam_req_if;
  logic                       valid;
  logic                       ready;
  logic                       command;
  logic [spam_pkg::POS_W-1:0]  pos_x;
  logic [spam_pkg::POS_W-1:0]  pos_y;
  logic [spam_pkg::CHAN_W-1:0] red;
  logic [spam_pkg::CHAN_W-1:0] green;
  logic [spam_pkg::CHAN_W-1:0] blue;

  modport source(output valid, command, pos_x, pos_y, red, green, blue, input ready);
  modport sink(input valid, command, pos_x, pos_y, red, green, blue, output ready);
endinterface

interface spam_res_if;
  logic                       valid;
  logic                       ready;
  logic                       masked;
  logic                       newly_masked;
  logic [spam_pkg::AGE_W-1:0]  age_now;

  modport source(output valid, masked, newly_masked, age_now, input ready);
  modport sink(input valid, masked, newly_masked, age_now, output ready);
endinterface

`default_nettype wire

// ===== design/static_pixel_age_masker_core.sv =====
// static pixel age masker: request and pixel ram read registered, then the result;
// one request per cycle while results are taken and the pixel ram is not busy
// reset: the pixel ram is zeroed one entry a cycle, every entry, with req.ready
// low; config writes still taken
// depends on spam_pkg, spam_ifs, spam_cfg, spam_mem, spam_upd
`timescale 1ns / 1ps
`default_nettype none

module static_pixel_age_masker_core #(
  parameter int LINE_PIXELS = 1024,
  parameter int FRAME_LINES = 1024
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  spam_req_if.sink                         req,
  spam_res_if.source                       res,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [spam_pkg::APB_AW-1:0] paddr,
  input  wire logic [spam_pkg::APB_DW-1:0] pwdata,
  output logic      [spam_pkg::APB_DW-1:0] prdata,
  output logic                             pready
);

  localparam int XW = $clog2(LINE_PIXELS < spam_pkg::POS_SPAN ? LINE_PIXELS
                                                               : spam_pkg::POS_SPAN);
  localparam int YW = $clog2(FRAME_LINES < spam_pkg::POS_SPAN ? FRAME_LINES
                                                               : spam_pkg::POS_SPAN);
  localparam int AW = XW + YW;

  spam_pkg::cfg_t    cfg;
  spam_pkg::entry_t  rdata;
  spam_pkg::entry_t  stored;
  spam_pkg::entry_t  upd_wdata;
  spam_pkg::result_t upd_result;
  logic              upd_we;
  logic              busy;
  logic              req_fire;
  logic              s1_adv;
  logic              mem_we;
  logic [AW-1:0]     req_addr;
  logic              req_in_frame;

  logic              s1_valid;
  logic              s1_command;
  logic              s1_in_frame;
  logic [AW-1:0]     s1_addr;
  spam_pkg::colour_t s1_colour;

  logic              lw_valid;
  logic [AW-1:0]     lw_addr;
  spam_pkg::entry_t  lw_data;

  logic              out_valid;
  spam_pkg::result_t out_result;

  spam_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign req_addr     = {req.pos_y[YW-1:0], req.pos_x[XW-1:0]};
  assign req_in_frame = (32'(req.pos_x) < LINE_PIXELS) && (32'(req.pos_y) < FRAME_LINES);

  assign s1_adv    = s1_valid && (!out_valid || res.ready);
  assign req.ready = !busy && (!s1_valid || s1_adv);
  assign req_fire  = req.valid && req.ready;
  assign mem_we    = s1_adv && upd_we;

  spam_mem #(
    .AW (AW)
  ) u_mem (
    .clk   (clk),
    .rst   (rst),
    .re    (req_fire),
    .raddr (req_addr),
    .rdata (rdata),
    .we    (mem_we),
    .waddr (s1_addr),
    .wdata (upd_wdata),
    .busy  (busy)
  );

  // the read issued alongside the previous write sees old data
  assign stored = (lw_valid && lw_addr == s1_addr) ? lw_data : rdata;

  spam_upd u_upd (
    .command  (s1_command),
    .in_frame (s1_in_frame),
    .colour   (s1_colour),
    .stored   (stored),
    .cfg      (cfg),
    .we       (upd_we),
    .wdata    (upd_wdata),
    .result   (upd_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      lw_valid  <= 1'b0;
    end else begin
      if (req_fire) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
      if (mem_we) begin
        lw_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      s1_command   <= req.command;
      s1_in_frame  <= req_in_frame;
      s1_addr      <= req_addr;
      s1_colour    <= '{red: req.red, green: req.green, blue: req.blue};
    end
    if (mem_we) begin
      lw_addr <= s1_addr;
      lw_data <= upd_wdata;
    end
    if (s1_adv) begin
      out_result <= upd_result;
    end
  end

  assign res.valid        = out_valid;
  assign res.masked       = out_result.masked;
  assign res.newly_masked = out_result.newly_masked;
  assign res.age_now      = out_result.age_now;

endmodule

`default_nettype wire

// ===== design/spam_cfg.sv =====
// apb register block: read and write threshold and max age
// depends on spam_pkg
`timescale 1ns / 1ps
`default_nettype none

module spam_cfg (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [spam_pkg::APB_AW-1:0] paddr,
  input  wire logic [spam_pkg::APB_DW-1:0] pwdata,
  output logic      [spam_pkg::APB_DW-1:0] prdata,
  output logic                             pready,
  output spam_pkg::cfg_t                   cfg
);

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold <= spam_pkg::THRESHOLD_RESET;
      cfg.max_age   <= spam_pkg::MAX_AGE_RESET;
    end else if (wr) begin
      unique case (paddr[2])
        spam_pkg::REG_THRESHOLD: cfg.threshold <= pwdata[spam_pkg::CHAN_W-1:0];
        spam_pkg::REG_MAX_AGE:   cfg.max_age   <= pwdata[spam_pkg::AGE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      spam_pkg::REG_THRESHOLD: prdata = {{(spam_pkg::APB_DW-spam_pkg::CHAN_W){1'b0}},
                                         cfg.threshold};
      spam_pkg::REG_MAX_AGE:   prdata = {{(spam_pkg::APB_DW-spam_pkg::AGE_W){1'b0}},
                                         cfg.max_age};
      default:                 prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== design/spam_mem.sv =====
// per-pixel store: colour, age and mask in one synchronous ram
// one write and one registered read a cycle, zeroing sweep after reset
// depends on spam_pkg
`timescale 1ns / 1ps
`default_nettype none

module spam_mem #(
  parameter int AW = 20
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output spam_pkg::entry_t      rdata,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire spam_pkg::entry_t wdata,
  output logic                  busy
);

  spam_pkg::entry_t mem [1 << AW];

  logic [AW-1:0]     clr_addr;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  spam_pkg::entry_t  mem_wdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (&clr_addr) begin
        busy <= 1'b0;
      end
    end
  end

  always_comb begin
    if (busy) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else begin
      mem_we    = we;
      mem_waddr = waddr;
      mem_wdata = wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== design/spam_upd.sv =====
// modify step: compares the captured colour with the stored entry
// and works out the new entry and the result
// depends on spam_pkg
`timescale 1ns / 1ps
`default_nettype none

module spam_upd (
  input  wire logic              command,
  input  wire logic              in_frame,
  input  wire spam_pkg::colour_t colour,
  input  wire spam_pkg::entry_t  stored,
  input  wire spam_pkg::cfg_t    cfg,
  output logic                   we,
  output spam_pkg::entry_t       wdata,
  output spam_pkg::result_t      result
);

  logic                       changed;
  logic [spam_pkg::AGE_W-1:0] age_inc;

  assign changed =
      (spam_pkg::abs_diff(colour.red,   stored.colour.red)   >= cfg.threshold) ||
      (spam_pkg::abs_diff(colour.green, stored.colour.green) >= cfg.threshold) ||
      (spam_pkg::abs_diff(colour.blue,  stored.colour.blue)  >= cfg.threshold);

  assign age_inc = stored.age + 1'b1;
  assign we      = in_frame;

  always_comb begin
    wdata  = stored;
    result = '0;
    if (command == spam_pkg::CMD_CLEAR) begin
      wdata.age  = '0;
      wdata.mask = 1'b0;
    end else if (stored.mask) begin
      wdata.colour   = colour;
      result.masked  = 1'b1;
      result.age_now = stored.age;
    end else begin
      wdata.colour = colour;
      if (changed) begin
        wdata.age = '0;
      end else if (age_inc >= cfg.max_age) begin
        wdata.age           = '0;
        wdata.mask          = 1'b1;
        result.masked       = 1'b1;
        result.newly_masked = 1'b1;
      end else begin
        wdata.age      = age_inc;
        result.age_now = age_inc;
      end
    end
    if (!in_frame) begin
      result = '0;
    end
  end

endmodule

`default_nettype wire

// ===== sim/static_pixel_age_masker_core_tb.sv =====
// testbench for static_pixel_age_masker_core: a directed table, then random pixel streams
// checked result by result against an in-bench model of the per-pixel colour, age and mask stores
// depends on spam_pkg, spam_ifs and the static_pixel_age_masker_core rtl
`timescale 1ns / 1ps

module static_pixel_age_masker_core_tb;

  localparam int CYCLE_LIMIT  = 4_000_000;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 175;
  localparam int POOL_N       = 4;
  localparam int DIR_N        = 24;
  localparam int HOLD_CYCLES  = 64;
  localparam int DRAIN_CYCLES = 8;

  localparam logic CMP  = spam_pkg::CMD_COMPARE;
  localparam logic CLR  = spam_pkg::CMD_CLEAR;
  localparam logic THR  = spam_pkg::REG_THRESHOLD;
  localparam logic MAXA = spam_pkg::REG_MAX_AGE;

  localparam logic [7:0] PHASE_THR [PHASES] = '{8'd3, 8'd255, 8'd0, 8'd1, 8'd12, 8'd2};
  localparam logic [7:0] PHASE_MAX [PHASES] = '{8'd4, 8'd255, 8'd1, 8'd0, 8'd8, 8'd150};

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct packed {
    logic                       command;
    logic [spam_pkg::POS_W-1:0] x;
    logic [spam_pkg::POS_W-1:0] y;
    spam_pkg::colour_t          colour;
  } pixel_req_t;

  typedef struct packed {
    row_kind_t          kind;
    logic               reg_code;
    logic [7:0]         value;
    pixel_req_t         rq;
    logic               fixed;
    spam_pkg::result_t  want;
  } dir_row_t;

  localparam spam_pkg::result_t R_ZERO = '{1'b0, 1'b0, 8'd0};
  localparam spam_pkg::result_t R_AGE1 = '{1'b0, 1'b0, 8'd1};
  localparam spam_pkg::result_t R_NEW  = '{1'b1, 1'b1, 8'd0};
  localparam spam_pkg::result_t R_HELD = '{1'b1, 1'b0, 8'd0};

  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    '{ROW_REQ, THR, 8'd0, '{CMP, 10'd0, 10'd0, 24'h000000}, 1'b1, R_AGE1},
    '{ROW_REQ, THR, 8'd0, '{CMP, 10'd1023, 10'd1023, 24'hffffff}, 1'b1, R_ZERO},
    '{ROW_REQ, THR, 8'd0, '{CMP, 10'd1023, 10'd1023, 24'hfefffe}, 1'b1, R_AGE1},
    '{ROW_REQ, THR, 8'd0, '{CMP, 10'd0, 10'd1023, 24'h000002}, 1'b1, R_ZERO},
    '{ROW_REQ, THR, 8'd0, '{CLR, 10'd1023, 10'd1023, 24'hffffff}, 1'b1, R_ZERO},
    '{ROW_REQ, THR, 8'd0, '{CMP, 10'd1023, 10'd1023, 24'hfefffe}, 1'b0, R_ZERO},
    '{ROW_CFG, MAXA, 8'd2, '{CMP, 10'd0, 10'd0, 24'h0}, 1'b0, R_ZERO},
    '{ROW_REQ, THR, 8'd0, '{CMP, 10'd1023, 10'd1023, 24'hfefffe}, 1'b1, R_NEW},
    '{ROW_REQ, THR, 8'd0, '{CMP, 10'd1023, 10'd1023, 24'h000000}, 1'b1, R_HELD},
    '{ROW_REQ, THR, 8'd0, '{CMP, 10'd0, 10'd0, 24'h010101}, 1'b0, R_ZERO},
    '{ROW_CFG, THR, 8'd0, '{CMP, 10'd0, 10'd0, 24'h0}, 1'b0, R_ZERO},
    '{ROW_REQ, THR, 8'd0, '{CMP, 10'd0, 10'd1023, 24'h000002}, 1'b1, R_ZERO},
    '{ROW_CFG, THR, 8'd255, '{CMP, 10'd0, 10'd0, 24'h0}, 1'b0, R_ZERO},
    '{ROW_REQ, THR, 8'd0, '{CMP, 10'd512, 10'd341, 24'haa55aa}, 1'b0, R_ZERO},
    '{ROW_CFG, MAXA, 8'd0, '{CMP, 10'd0, 10'd0, 24'h0}, 1'b0, R_ZERO},
    '{ROW_REQ, THR, 8'd0, '{CMP, 10'd341, 10'd682, 24'h55aa55}, 1'b1, R_NEW},
    '{ROW_REQ, THR, 8'd0, '{CMP, 10'd100, 10'd200, 24'hff0000}, 1'b1, R_ZERO},
    '{ROW_CFG, THR, 8'd2, '{CMP, 10'd0, 10'd0, 24'h0}, 1'b0, R_ZERO},
    '{ROW_CFG, MAXA, 8'd150, '{CMP, 10'd0, 10'd0, 24'h0}, 1'b0, R_ZERO},
    '{ROW_REQ, THR, 8'd0, '{CMP, 10'd700, 10'd300, 24'h123456}, 1'b0, R_ZERO},
    '{ROW_REQ, THR, 8'd0, '{CMP, 10'd700, 10'd300, 24'h123456}, 1'b0, R_ZERO},
    '{ROW_REQ, THR, 8'd0, '{CMP, 10'd700, 10'd300, 24'h123456}, 1'b0, R_ZERO},
    '{ROW_CFG, MAXA, 8'd2, '{CMP, 10'd0, 10'd0, 24'h0}, 1'b0, R_ZERO},
    '{ROW_REQ, THR, 8'd0, '{CMP, 10'd700, 10'd300, 24'h123456}, 1'b0, R_ZERO}
  };

  logic                        clk;
  logic                        rst;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [spam_pkg::APB_AW-1:0] paddr;
  logic [spam_pkg::APB_DW-1:0] pwdata;
  logic [spam_pkg::APB_DW-1:0] prdata;
  logic                        pready;

  spam_req_if req_ch ();
  spam_res_if res_ch ();

  static_pixel_age_masker_core dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .res     (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // per-pixel stores, keyed by row * POS_SPAN + column; missing entries read as zero
  spam_pkg::colour_t          rgb_store  [int];
  logic [spam_pkg::AGE_W-1:0] age_store  [int];
  bit                         mask_store [int];
  logic [7:0]                 cur_threshold = spam_pkg::THRESHOLD_RESET;
  logic [7:0]                 cur_max_age   = spam_pkg::MAX_AGE_RESET;

  spam_pkg::result_t status_due [$];
  int      mismatches   = 0;
  int      cycles       = 0;
  int      src_idle_pct = 0;
  int      snk_idle_pct = 0;
  int      hold_left    = 0;
  bit      hold_pending = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("static_pixel_age_masker_core: mismatch");
      $finish;
    end
  end

  function automatic int pixel_index(logic [spam_pkg::POS_W-1:0] x,
                                     logic [spam_pkg::POS_W-1:0] y);
    return int'(y) * spam_pkg::POS_SPAN + int'(x);
  endfunction

  function automatic spam_pkg::colour_t stored_colour(logic [spam_pkg::POS_W-1:0] x,
                                                      logic [spam_pkg::POS_W-1:0] y);
    int idx;
    idx = pixel_index(x, y);
    return rgb_store.exists(idx) ? rgb_store[idx] : spam_pkg::colour_t'('0);
  endfunction

  function automatic logic [7:0] chan_gap(logic [7:0] a, logic [7:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic spam_pkg::result_t predict_pixel_status(pixel_req_t rq);
    int                         idx;
    spam_pkg::colour_t          last;
    logic [spam_pkg::AGE_W-1:0] age;
    bit                         moved;
    spam_pkg::result_t          st;
    st  = R_ZERO;
    idx = pixel_index(rq.x, rq.y);
    if (rq.command == spam_pkg::CMD_CLEAR) begin
      age_store[idx]  = '0;
      mask_store[idx] = 1'b0;
      return st;
    end
    last = stored_colour(rq.x, rq.y);
    rgb_store[idx] = rq.colour;
    if (mask_store.exists(idx) && mask_store[idx]) begin
      st.masked  = 1'b1;
      st.age_now = age_store[idx];
      return st;
    end
    moved = chan_gap(rq.colour.red, last.red) >= cur_threshold ||
            chan_gap(rq.colour.green, last.green) >= cur_threshold ||
            chan_gap(rq.colour.blue, last.blue) >= cur_threshold;
    age = '0;
    if (!moved) begin
      age = (age_store.exists(idx) ? age_store[idx] : spam_pkg::AGE_W'(0)) + 1'b1;
      if (age >= cur_max_age) begin
        mask_store[idx] = 1'b1;
        age = '0;
        st.newly_masked = 1'b1;
      end
    end
    age_store[idx] = age;
    st.masked  = mask_store.exists(idx) ? mask_store[idx] : 1'b0;
    st.age_now = age;
    return st;
  endfunction

  // small per-channel drift, mostly under the threshold, now and then right at it
  function automatic logic [7:0] drift(logic [7:0] c);
    int d;
    int v;
    if (cur_threshold == 0)
      d = 0;
    else if ($urandom_range(0, 31) == 0)
      d = int'(cur_threshold);
    else
      d = $urandom_range(0, int'(cur_threshold) - 1);
    v = $urandom_range(0, 1) ? int'(c) + d : int'(c) - d;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t error: %s got %0d want %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic check_status(spam_pkg::result_t got);
    spam_pkg::result_t want;
    if (status_due.size() == 0) begin
      report_mismatch("result with no request pending, age_now", int'(got.age_now), -1);
      return;
    end
    want = status_due.pop_front();
    if (got.masked !== want.masked)
      report_mismatch("masked", int'(got.masked), int'(want.masked));
    if (got.newly_masked !== want.newly_masked)
      report_mismatch("newly_masked", int'(got.newly_masked), int'(want.newly_masked));
    if (got.age_now !== want.age_now)
      report_mismatch("age_now", int'(got.age_now), int'(want.age_now));
  endtask

  task automatic send_pixel(pixel_req_t rq, bit fixed, spam_pkg::result_t want);
    spam_pkg::result_t st;
    @(negedge clk);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.command <= rq.command;
    req_ch.pos_x   <= rq.x;
    req_ch.pos_y   <= rq.y;
    req_ch.red     <= rq.colour.red;
    req_ch.green   <= rq.colour.green;
    req_ch.blue    <= rq.colour.blue;
    do @(posedge clk); while (!req_ch.ready);
    st = predict_pixel_status(rq);
    status_due.push_back(fixed ? want : st);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(logic reg_code, logic [7:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_code, 2'b00};
    pwdata  <= {24'd0, value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (reg_code == spam_pkg::REG_THRESHOLD)
      cur_threshold = value;
    else
      cur_max_age = value;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // result side: random stalls, plus one long hold-off when asked
  initial begin
    spam_pkg::result_t got;
    forever begin
      @(posedge clk);
      if (!rst && res_ch.valid && res_ch.ready) begin
        got = '{res_ch.masked, res_ch.newly_masked, res_ch.age_now};
        check_status(got);
      end
      @(negedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
      end
    end
  end

  initial begin
    logic [spam_pkg::POS_W-1:0] pool_x [POOL_N];
    logic [spam_pkg::POS_W-1:0] pool_y [POOL_N];
    pixel_req_t                 rq;
    spam_pkg::colour_t          prev;
    int                         kind;
    int                         slot;

    rst            = 1'b1;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    req_ch.valid   = 1'b0;
    req_ch.command = spam_pkg::CMD_COMPARE;
    req_ch.pos_x   = '0;
    req_ch.pos_y   = '0;
    req_ch.red     = '0;
    req_ch.green   = '0;
    req_ch.blue    = '0;
    res_ch.ready   = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    src_idle_pct = 20;
    snk_idle_pct = 52;
    for (int i = 0; i < DIR_N; i++) begin
      if (DIR_ROWS[i].kind == ROW_CFG) begin
        wait_idle();
        apb_write(DIR_ROWS[i].reg_code, DIR_ROWS[i].value);
      end else begin
        send_pixel(DIR_ROWS[i].rq, DIR_ROWS[i].fixed, DIR_ROWS[i].want);
      end
    end

    for (int s = 0; s < POOL_N; s++) begin
      pool_x[s] = spam_pkg::POS_W'($urandom);
      pool_y[s] = spam_pkg::POS_W'($urandom);
    end

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      apb_write(spam_pkg::REG_THRESHOLD, PHASE_THR[p]);
      apb_write(spam_pkg::REG_MAX_AGE, PHASE_MAX[p]);
      src_idle_pct = (p < 2) ? 20 : (p < 4) ? 52 : 0;
      snk_idle_pct = (p < 2) ? 52 : (p < 4) ? 20 : 0;
      if (p == 0 || p == 4) hold_pending = 1'b1;
      // keep some pixels across phases so ages built under one setting meet the next
      for (int s = 0; s < POOL_N; s++) begin
        if ($urandom_range(0, 1)) begin
          pool_x[s] = spam_pkg::POS_W'($urandom);
          pool_y[s] = spam_pkg::POS_W'($urandom);
        end
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        kind       = $urandom_range(0, 99);
        slot       = $urandom_range(0, POOL_N - 1);
        rq.command = spam_pkg::CMD_COMPARE;
        rq.x       = pool_x[slot];
        rq.y       = pool_y[slot];
        if (kind < 70) begin
          prev      = stored_colour(rq.x, rq.y);
          rq.colour = '{drift(prev.red), drift(prev.green), drift(prev.blue)};
        end else if (kind < 80) begin
          rq.command = spam_pkg::CMD_CLEAR;
          rq.colour  = spam_pkg::COLOUR_W'($urandom);
        end else if (kind < 90) begin
          rq.x      = spam_pkg::POS_W'($urandom);
          rq.y      = spam_pkg::POS_W'($urandom);
          rq.colour = spam_pkg::COLOUR_W'($urandom);
        end else begin
          rq.colour = spam_pkg::COLOUR_W'($urandom);
        end
        send_pixel(rq, 1'b0, R_ZERO);
      end
    end

    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("static_pixel_age_masker_core: match");
    else
      $display("static_pixel_age_masker_core: mismatch");
    $finish;
  end

endmodule
